// File: design/bcm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bcm_pkg;

    // Default sizes of the parameterized parts.
    localparam int ADC_BITS_DEF   = 12;
    localparam int COUNT_BITS_DEF = 16;

    // Fixed field widths.
    localparam int REF_W      = 22;
    localparam int GAIN_W     = 20;
    localparam int RG_W       = REF_W + GAIN_W;
    localparam int HALF_W     = RG_W / 2;
    localparam int FRAC_W     = 16;
    localparam int SUM_W      = 48;
    localparam int AVG_W      = 32;
    localparam int RPT_CNT_W  = 16;
    localparam int OUT_TDATA_W = ((AVG_W + RPT_CNT_W + 7) / 8) * 8;

    // Shared divider: four quotient bits per cycle over a 48-bit dividend.
    localparam int DVD_W     = 48;
    localparam int DIV_RADIX = 4;
    localparam int DIV_ITERS = DVD_W / DIV_RADIX;
    localparam int ITER_W    = $clog2(DIV_ITERS);

    // Configuration port.
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [1:0] REG_REF_UV     = 2'd0;
    localparam logic [1:0] REG_GAIN_ONE   = 2'd1;
    localparam logic [1:0] REG_GAIN_TWO   = 2'd2;
    localparam logic [1:0] REG_GAIN_THREE = 2'd3;

    localparam logic [REF_W-1:0]  RST_REF_UV     = REF_W'(1200000);
    localparam logic [GAIN_W-1:0] RST_GAIN_ONE   = GAIN_W'(387318);
    localparam logic [GAIN_W-1:0] RST_GAIN_TWO   = GAIN_W'(404921);
    localparam logic [GAIN_W-1:0] RST_GAIN_THREE = GAIN_W'(405438);

    typedef struct packed {
        logic [REF_W-1:0]  ref_uv;
        logic [GAIN_W-1:0] gain_one;
        logic [GAIN_W-1:0] gain_two;
        logic [GAIN_W-1:0] gain_three;
    } t_cfg;

    // Datapath operations carried by a control word.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_MUL_RG,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_ADD_HI,
        OP_DIV_LD_TAP,
        OP_DIV_LD_AVG,
        OP_DIV_STEP,
        OP_STORE,
        OP_ACCUM,
        OP_OUT_MIN,
        OP_OUT_EMPTY
    } t_op;

    // Jump conditions of a control word.
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_IN,
        C_REPORT,
        C_SKIP,
        C_ITER_NZ,
        C_EMPTY,
        C_OUT_BUSY
    } t_cond;

    typedef logic [1:0] t_sel;
    localparam t_sel SEL_ONE   = 2'd0;
    localparam t_sel SEL_TWO   = 2'd1;
    localparam t_sel SEL_THREE = 2'd2;

    localparam int PC_W = 6;
    typedef logic [PC_W-1:0] t_pc;

    typedef struct packed {
        t_op   op;
        t_sel  sel;
        t_cond cond;
        t_pc   target;
    } t_uword;

    typedef struct packed {
        t_op  op;
        t_sel sel;
    } t_dp_ctrl;

    typedef struct packed {
        logic report;
        logic skip;
        logic iter_nz;
        logic empty;
        logic out_busy;
    } t_dp_status;

    // Program layout.
    localparam t_pc PC_IDLE       = 6'd0;
    localparam t_pc PC_DISPATCH   = 6'd1;
    localparam t_pc PC_CHECK      = 6'd2;
    localparam t_pc PC_TAP1       = 6'd3;
    localparam t_pc PC_TAP2       = 6'd10;
    localparam t_pc PC_TAP3       = 6'd17;
    localparam t_pc PC_ACCUM      = 6'd24;
    localparam t_pc PC_REPORT     = 6'd25;
    localparam t_pc PC_AVG1       = 6'd26;
    localparam t_pc PC_AVG2       = 6'd29;
    localparam t_pc PC_AVG3       = 6'd32;
    localparam t_pc PC_WAIT_MIN   = 6'd35;
    localparam t_pc PC_OUT_MIN    = 6'd36;
    localparam t_pc PC_WAIT_EMPTY = 6'd37;
    localparam t_pc PC_OUT_EMPTY  = 6'd38;

    // Offsets inside one tap conversion block.
    localparam logic [2:0] TAP_MUL_RG   = 3'd0;
    localparam logic [2:0] TAP_MUL_LO   = 3'd1;
    localparam logic [2:0] TAP_MUL_HI   = 3'd2;
    localparam logic [2:0] TAP_ADD_HI   = 3'd3;
    localparam logic [2:0] TAP_DIV_LD   = 3'd4;
    localparam logic [2:0] TAP_DIV_STEP = 3'd5;
    localparam logic [2:0] TAP_STORE    = 3'd6;

    // Offsets inside one average block.
    localparam logic [1:0] AVG_DIV_LD   = 2'd0;
    localparam logic [1:0] AVG_DIV_STEP = 2'd1;
    localparam logic [1:0] AVG_STORE    = 2'd2;

    // Control store. Taps and averages repeat one block per cell.
    function automatic t_uword f_ucode(input t_pc pc);
        t_uword     w;
        t_sel       sel;
        t_pc        base;
        logic [2:0] tofs;
        logic [1:0] aofs;
        w    = '{OP_NOP, SEL_ONE, C_ALWAYS, PC_IDLE};
        sel  = SEL_ONE;
        base = PC_TAP1;
        tofs = 3'd0;
        aofs = 2'd0;
        if (pc >= PC_TAP1 && pc < PC_ACCUM) begin
            if (pc >= PC_TAP3) begin
                sel  = SEL_THREE;
                base = PC_TAP3;
            end else if (pc >= PC_TAP2) begin
                sel  = SEL_TWO;
                base = PC_TAP2;
            end
            tofs     = 3'(pc - base);
            w.sel    = sel;
            w.cond   = C_NEVER;
            w.target = pc;
            case (tofs)
                TAP_MUL_RG:   w.op = OP_MUL_RG;
                TAP_MUL_LO:   w.op = OP_MUL_LO;
                TAP_MUL_HI:   w.op = OP_MUL_HI;
                TAP_ADD_HI:   w.op = OP_ADD_HI;
                TAP_DIV_LD:   w.op = OP_DIV_LD_TAP;
                TAP_DIV_STEP: begin
                    w.op   = OP_DIV_STEP;
                    w.cond = C_ITER_NZ;
                end
                TAP_STORE:    w.op = OP_STORE;
                default:      w.op = OP_NOP;
            endcase
        end else if (pc >= PC_AVG1 && pc < PC_WAIT_MIN) begin
            base = PC_AVG1;
            if (pc >= PC_AVG3) begin
                sel  = SEL_THREE;
                base = PC_AVG3;
            end else if (pc >= PC_AVG2) begin
                sel  = SEL_TWO;
                base = PC_AVG2;
            end
            aofs     = 2'(pc - base);
            w.sel    = sel;
            w.cond   = C_NEVER;
            w.target = pc;
            case (aofs)
                AVG_DIV_LD:   w.op = OP_DIV_LD_AVG;
                AVG_DIV_STEP: begin
                    w.op   = OP_DIV_STEP;
                    w.cond = C_ITER_NZ;
                end
                AVG_STORE:    w.op = OP_STORE;
                default:      w.op = OP_NOP;
            endcase
        end else begin
            case (pc)
                PC_IDLE:       w = '{OP_NOP, SEL_ONE, C_NO_IN, PC_IDLE};
                PC_DISPATCH:   w = '{OP_NOP, SEL_ONE, C_REPORT, PC_REPORT};
                PC_CHECK:      w = '{OP_NOP, SEL_ONE, C_SKIP, PC_IDLE};
                PC_ACCUM:      w = '{OP_ACCUM, SEL_ONE, C_ALWAYS, PC_IDLE};
                PC_REPORT:     w = '{OP_NOP, SEL_ONE, C_EMPTY, PC_WAIT_EMPTY};
                PC_WAIT_MIN:   w = '{OP_NOP, SEL_ONE, C_OUT_BUSY, PC_WAIT_MIN};
                PC_OUT_MIN:    w = '{OP_OUT_MIN, SEL_ONE, C_ALWAYS, PC_IDLE};
                PC_WAIT_EMPTY: w = '{OP_NOP, SEL_ONE, C_OUT_BUSY, PC_WAIT_EMPTY};
                PC_OUT_EMPTY:  w = '{OP_OUT_EMPTY, SEL_ONE, C_ALWAYS, PC_IDLE};
                default:       w = '{OP_NOP, SEL_ONE, C_ALWAYS, PC_IDLE};
            endcase
        end
        return w;
    endfunction

endpackage

`default_nettype wire

// File: design/battery_cell_min_average_monitor.sv
`timescale 1ns / 1ps
// A sample set runs the check, three tap conversions and accumulate before the next is taken.
// A sample set with a zero reference code or a full count is dropped at the check step.
// An end-of-period transaction runs the three averages (skipped if empty), then loads its result.
// Throughput is set by the shared multiplier and the divider loop run by the program.
// Synchronous active-low reset restores register defaults and clears sums and count at once.
`default_nettype none

module battery_cell_min_average_monitor #(
    parameter int ADC_BITS   = bcm_pkg::ADC_BITS_DEF,
    parameter int COUNT_BITS = bcm_pkg::COUNT_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,

    // Configuration port.
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [bcm_pkg::CFG_ADDR_W-1:0]        paddr,
    input  logic [bcm_pkg::CFG_DATA_W-1:0]        pwdata,
    output logic [bcm_pkg::CFG_DATA_W-1:0]        prdata,
    output logic                                  pready,

    // Sample stream.
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // reference_sample, tap_one_sample, tap_two_sample, tap_three_sample
    input  logic [((4*ADC_BITS+7)/8)*8-1:0]       s_axis_tdata,
    // action
    input  logic                                  s_axis_tuser,

    // Report stream.
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // min_cell_average, reads_in_period
    output logic [bcm_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    // period_empty
    output logic                                  m_axis_tuser
);
    import bcm_pkg::*;

    t_cfg                 r_cfg;
    t_dp_ctrl             w_ctrl;
    t_dp_status           w_status;
    logic                 w_ready;
    logic                 w_accept;
    logic                 w_cfg_wr;
    logic [AVG_W-1:0]     w_min_avg;
    logic [RPT_CNT_W-1:0] w_reads;

    // Register writes land on the access phase; pready is tied high so every
    // access completes without wait states. Addresses are word aligned, four bytes apart.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ref_uv     <= RST_REF_UV;
            r_cfg.gain_one   <= RST_GAIN_ONE;
            r_cfg.gain_two   <= RST_GAIN_TWO;
            r_cfg.gain_three <= RST_GAIN_THREE;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_REF_UV:     r_cfg.ref_uv     <= pwdata[REF_W-1:0];
                REG_GAIN_ONE:   r_cfg.gain_one   <= pwdata[GAIN_W-1:0];
                REG_GAIN_TWO:   r_cfg.gain_two   <= pwdata[GAIN_W-1:0];
                REG_GAIN_THREE: r_cfg.gain_three <= pwdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Reads return the register value, zero-extended to the bus.
    always_comb begin
        case (paddr[3:2])
            REG_REF_UV:     prdata = CFG_DATA_W'(r_cfg.ref_uv);
            REG_GAIN_ONE:   prdata = CFG_DATA_W'(r_cfg.gain_one);
            REG_GAIN_TWO:   prdata = CFG_DATA_W'(r_cfg.gain_two);
            REG_GAIN_THREE: prdata = CFG_DATA_W'(r_cfg.gain_three);
            default:        prdata = '0;
        endcase
    end

    // The input is taken only while the program sits in its idle step. The
    // result is held in its own output register, so a new transaction can be
    // accepted while an earlier report still waits for the sink.
    assign s_axis_tready = w_ready;
    assign w_accept      = s_axis_tvalid && w_ready;

    // The sequencer steps through the control store; each word names one
    // datapath operation, the cell it applies to, and a conditional jump.
    bcm_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_status   (w_status),
        .o_ready    (w_ready),
        .o_ctrl     (w_ctrl)
    );

    // The datapath holds the shared multiplier, the divider, the tap and
    // average registers, the running sums and the output register.
    bcm_dp #(
        .ADC_BITS   (ADC_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_accept    (w_accept),
        .i_action    (s_axis_tuser),
        .i_ref_code  (s_axis_tdata[ADC_BITS-1:0]),
        .i_tap_one   (s_axis_tdata[2*ADC_BITS-1:ADC_BITS]),
        .i_tap_two   (s_axis_tdata[3*ADC_BITS-1:2*ADC_BITS]),
        .i_tap_three (s_axis_tdata[4*ADC_BITS-1:3*ADC_BITS]),
        .i_ctrl      (w_ctrl),
        .o_status    (w_status),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_min_avg   (w_min_avg),
        .o_empty     (m_axis_tuser),
        .o_reads     (w_reads)
    );

    assign m_axis_tdata = OUT_TDATA_W'({w_reads, w_min_avg});

endmodule

`default_nettype wire

// File: design/bcm_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module bcm_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  bcm_pkg::t_dp_status   i_status,
    output logic                  o_ready,
    output bcm_pkg::t_dp_ctrl     o_ctrl
);
    import bcm_pkg::*;

    t_pc    r_pc;
    t_pc    n_pc;
    t_uword w_word;
    logic   w_jump;

    assign w_word = f_ucode(r_pc);

    // Next step: jump on a true condition, else fall through.
    always_comb begin
        case (w_word.cond)
            C_NEVER:    w_jump = 1'b0;
            C_ALWAYS:   w_jump = 1'b1;
            C_NO_IN:    w_jump = !i_in_valid;
            C_REPORT:   w_jump = i_status.report;
            C_SKIP:     w_jump = i_status.skip;
            C_ITER_NZ:  w_jump = i_status.iter_nz;
            C_EMPTY:    w_jump = i_status.empty;
            C_OUT_BUSY: w_jump = i_status.out_busy;
            default:    w_jump = 1'b0;
        endcase
        n_pc = w_jump ? w_word.target : r_pc + 1'b1;
    end

    // Outputs of the current control word.
    always_comb begin
        o_ready    = (r_pc == PC_IDLE);
        o_ctrl.op  = w_word.op;
        o_ctrl.sel = w_word.sel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ready && i_in_valid) |=> (r_pc == PC_DISPATCH))
        else $error("sequencer did not dispatch after a transaction");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctrl.op == OP_DIV_STEP && i_status.iter_nz) |=> (r_pc == $past(r_pc)))
        else $error("divider loop left early");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_word.cond == C_OUT_BUSY && !i_status.out_busy)
            |=> (o_ctrl.op == OP_OUT_MIN || o_ctrl.op == OP_OUT_EMPTY))
        else $error("output wait not followed by an output load");

endmodule

`default_nettype wire

// File: design/bcm_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module bcm_dp #(
    parameter int ADC_BITS   = bcm_pkg::ADC_BITS_DEF,
    parameter int COUNT_BITS = bcm_pkg::COUNT_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  bcm_pkg::t_cfg                         i_cfg,
    input  logic                                  i_accept,
    input  logic                                  i_action,
    input  logic [ADC_BITS-1:0]                   i_ref_code,
    input  logic [ADC_BITS-1:0]                   i_tap_one,
    input  logic [ADC_BITS-1:0]                   i_tap_two,
    input  logic [ADC_BITS-1:0]                   i_tap_three,
    input  bcm_pkg::t_dp_ctrl                     i_ctrl,
    output bcm_pkg::t_dp_status                   o_status,
    input  logic                                  i_out_ready,
    output logic                                  o_out_valid,
    output logic [bcm_pkg::AVG_W-1:0]             o_min_avg,
    output logic                                  o_empty,
    output logic [bcm_pkg::RPT_CNT_W-1:0]         o_reads
);
    import bcm_pkg::*;

    localparam int DVS_W  = (ADC_BITS > COUNT_BITS) ? ADC_BITS : COUNT_BITS;
    localparam int NUM_W  = RG_W + ADC_BITS;
    localparam int CNTX_W = (COUNT_BITS > RPT_CNT_W) ? COUNT_BITS : RPT_CNT_W;

    // Latched sample set.
    logic                 r_action;
    logic [ADC_BITS-1:0]  r_ref_code;
    logic [ADC_BITS-1:0]  r_code [3];

    // Multiplier path.
    logic [REF_W-1:0]     w_mul_a;
    logic [GAIN_W-1:0]    w_mul_b;
    logic [RG_W-1:0]      w_mul_p;
    logic [GAIN_W-1:0]    w_gain;
    logic [ADC_BITS-1:0]  w_code;
    logic [RG_W-1:0]      r_rg;
    logic [RG_W-1:0]      r_mul;
    logic [NUM_W-1:0]     r_num;

    // Divider.
    logic [DVD_W-1:0]     r_quo;
    logic [DVS_W-1:0]     r_rem;
    logic [DVS_W-1:0]     r_dvs;
    logic [ITER_W-1:0]    r_iter;
    logic                 r_neg;
    logic [DVD_W-1:0]     w_quo;
    logic [DVS_W-1:0]     w_rem;
    logic [DVS_W:0]       w_trial;

    // Tap voltages, later the per-cell averages.
    logic signed [SUM_W-1:0] r_val [3];

    // Running state.
    logic signed [SUM_W-1:0] r_sum [3];
    logic [COUNT_BITS-1:0]   r_count;
    logic signed [SUM_W-1:0] w_sum_sel;
    logic signed [SUM_W:0]   w_cell [3];
    logic signed [SUM_W+1:0] w_wide [3];
    logic signed [SUM_W-1:0] w_sat  [3];

    // Report.
    logic signed [SUM_W-1:0] w_min;
    logic [AVG_W-1:0]        w_min_sat;
    logic [CNTX_W-1:0]       w_cnt_x;
    logic [RPT_CNT_W-1:0]    w_rpt;
    logic                    r_out_valid;
    logic [AVG_W-1:0]        r_out_avg;
    logic                    r_out_empty;
    logic [RPT_CNT_W-1:0]    r_out_cnt;

    always_comb begin
        case (i_ctrl.sel)
            SEL_ONE: begin
                w_gain = i_cfg.gain_one;
                w_code = r_code[0];
            end
            SEL_TWO: begin
                w_gain = i_cfg.gain_two;
                w_code = r_code[1];
            end
            default: begin
                w_gain = i_cfg.gain_three;
                w_code = r_code[2];
            end
        endcase
    end

    // The triple product (RG_W + ADC_BITS bits) is built as (R*G) split in halves times the code.
    always_comb begin
        case (i_ctrl.op)
            OP_MUL_RG: begin
                w_mul_a = i_cfg.ref_uv;
                w_mul_b = w_gain;
            end
            OP_MUL_LO: begin
                w_mul_a = REF_W'(r_rg[HALF_W-1:0]);
                w_mul_b = GAIN_W'(w_code);
            end
            OP_MUL_HI: begin
                w_mul_a = REF_W'(r_rg[RG_W-1:HALF_W]);
                w_mul_b = GAIN_W'(w_code);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
        w_mul_p = w_mul_a * w_mul_b;
    end

    // Restoring division, DIV_RADIX quotient bits per cycle.
    always_comb begin
        w_rem   = r_rem;
        w_quo   = r_quo;
        w_trial = '0;
        for (int i = 0; i < DIV_RADIX; i++) begin
            w_trial = {w_rem, w_quo[DVD_W-1]};
            w_quo   = {w_quo[DVD_W-2:0], 1'b0};
            if (w_trial >= {1'b0, r_dvs}) begin
                w_trial  = w_trial - {1'b0, r_dvs};
                w_quo[0] = 1'b1;
            end
            w_rem = w_trial[DVS_W-1:0];
        end
    end

    always_comb begin
        case (i_ctrl.sel)
            SEL_ONE: w_sum_sel = r_sum[0];
            SEL_TWO: w_sum_sel = r_sum[1];
            default: w_sum_sel = r_sum[2];
        endcase
    end

    // Cell voltages and saturating accumulation, one lane per cell.
    always_comb begin
        w_cell[0] = {r_val[0][SUM_W-1], r_val[0]};
        w_cell[1] = {r_val[1][SUM_W-1], r_val[1]} - {r_val[0][SUM_W-1], r_val[0]};
        w_cell[2] = {r_val[2][SUM_W-1], r_val[2]} - {r_val[1][SUM_W-1], r_val[1]};
        for (int k = 0; k < 3; k++) begin
            w_wide[k] = {{2{r_sum[k][SUM_W-1]}}, r_sum[k]} + {w_cell[k][SUM_W], w_cell[k]};
            if (w_wide[k][SUM_W+1:SUM_W-1] == 3'b000 || w_wide[k][SUM_W+1:SUM_W-1] == 3'b111) begin
                w_sat[k] = w_wide[k][SUM_W-1:0];
            end else if (w_wide[k][SUM_W+1]) begin
                w_sat[k] = {1'b1, {(SUM_W-1){1'b0}}};
            end else begin
                w_sat[k] = {1'b0, {(SUM_W-1){1'b1}}};
            end
        end
    end

    // Smallest average, saturated to 32 bits, and the clamped count.
    always_comb begin
        if (r_val[0] < r_val[1]) begin
            w_min = (r_val[0] < r_val[2]) ? r_val[0] : r_val[2];
        end else begin
            w_min = (r_val[1] < r_val[2]) ? r_val[1] : r_val[2];
        end
        if (w_min[SUM_W-1:AVG_W-1] == '0 || w_min[SUM_W-1:AVG_W-1] == '1) begin
            w_min_sat = w_min[AVG_W-1:0];
        end else if (w_min[SUM_W-1]) begin
            w_min_sat = {1'b1, {(AVG_W-1){1'b0}}};
        end else begin
            w_min_sat = {1'b0, {(AVG_W-1){1'b1}}};
        end
        w_cnt_x = CNTX_W'(r_count);
        if (w_cnt_x > CNTX_W'({RPT_CNT_W{1'b1}})) begin
            w_rpt = '1;
        end else begin
            w_rpt = w_cnt_x[RPT_CNT_W-1:0];
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_action   <= i_action;
            r_ref_code <= i_ref_code;
            r_code[0]  <= i_tap_one;
            r_code[1]  <= i_tap_two;
            r_code[2]  <= i_tap_three;
        end
        case (i_ctrl.op)
            OP_MUL_RG: r_rg <= w_mul_p;
            OP_MUL_LO: r_num <= NUM_W'(w_mul_p);
            OP_MUL_HI: r_mul <= w_mul_p;
            OP_ADD_HI: r_num <= r_num + (NUM_W'(r_mul) << HALF_W);
            OP_DIV_LD_TAP: begin
                r_quo  <= DVD_W'(r_num[NUM_W-1:FRAC_W]);
                r_rem  <= '0;
                r_dvs  <= DVS_W'(r_ref_code);
                r_iter <= ITER_W'(DIV_ITERS - 1);
                r_neg  <= 1'b0;
            end
            OP_DIV_LD_AVG: begin
                r_quo  <= w_sum_sel[SUM_W-1] ? DVD_W'(-w_sum_sel) : DVD_W'(w_sum_sel);
                r_rem  <= '0;
                r_dvs  <= DVS_W'(r_count);
                r_iter <= ITER_W'(DIV_ITERS - 1);
                r_neg  <= w_sum_sel[SUM_W-1];
            end
            OP_DIV_STEP: begin
                r_quo  <= w_quo;
                r_rem  <= w_rem;
                r_iter <= r_iter - 1'b1;
            end
            OP_STORE: begin
                r_val[i_ctrl.sel] <= r_neg ? -$signed(SUM_W'(r_quo)) : $signed(SUM_W'(r_quo));
            end
            OP_OUT_MIN: begin
                r_out_avg   <= w_min_sat;
                r_out_empty <= 1'b0;
                r_out_cnt   <= w_rpt;
            end
            OP_OUT_EMPTY: begin
                r_out_avg   <= '0;
                r_out_empty <= 1'b1;
                r_out_cnt   <= '0;
            end
            default: ;
        endcase
    end

    // Sums, count and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum[0]    <= '0;
            r_sum[1]    <= '0;
            r_sum[2]    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctrl.op == OP_ACCUM) begin
                r_sum[0] <= w_sat[0];
                r_sum[1] <= w_sat[1];
                r_sum[2] <= w_sat[2];
                r_count  <= r_count + 1'b1;
            end else if (i_ctrl.op == OP_OUT_MIN || i_ctrl.op == OP_OUT_EMPTY) begin
                r_sum[0] <= '0;
                r_sum[1] <= '0;
                r_sum[2] <= '0;
                r_count  <= '0;
            end
            if (i_ctrl.op == OP_OUT_MIN || i_ctrl.op == OP_OUT_EMPTY) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_status.report   = r_action;
        o_status.skip     = (r_ref_code == '0) || (&r_count);
        o_status.iter_nz  = (r_iter != '0);
        o_status.empty    = (r_count == '0);
        o_status.out_busy = r_out_valid && !i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_min_avg   = r_out_avg;
    assign o_empty     = r_out_empty;
    assign o_reads     = r_out_cnt;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.op == OP_OUT_MIN || i_ctrl.op == OP_OUT_EMPTY) |-> !r_out_valid)
        else $error("output register overwritten while holding a result");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.op == OP_ACCUM) |-> !(&r_count))
        else $error("sample set counted while the count is full");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.op == OP_DIV_LD_AVG) |-> (r_count != '0))
        else $error("average started with an empty period");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.op == OP_OUT_MIN || i_ctrl.op == OP_OUT_EMPTY)
            |=> (r_count == '0 && r_out_valid))
        else $error("period not cleared after a report");

endmodule

`default_nettype wire

// File: sim/battery_cell_min_average_monitor_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the battery cell minimum-average monitor.
// Sample sets and end-of-period markers go in on the sample stream. A scoreboard
// object keeps its own copy of the gain registers, the three cell sums and the
// read count. For every end-of-period transaction it predicts the report that
// has to appear on the report stream, and each report that comes out is checked
// field by field against the oldest prediction.
module battery_cell_min_average_monitor_tb;
    import bcm_pkg::*;

    localparam int ADC_W      = ADC_BITS_DEF;
    localparam int IN_TDATA_W = ((4 * ADC_W + 7) / 8) * 8;

    // Meaning of tuser on the sample stream.
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_REPORT = 1'b1;

    localparam longint      SUM_HI     = (longint'(1) <<< (SUM_W - 1)) - 1;
    localparam longint      SUM_LO     = -SUM_HI - 1;
    localparam longint      AVG_HI     = (longint'(1) <<< (AVG_W - 1)) - 1;
    localparam longint      AVG_LO     = -AVG_HI - 1;
    localparam int unsigned COUNT_FULL = (1 << COUNT_BITS_DEF) - 1;
    localparam int unsigned READS_FULL = (1 << RPT_CNT_W) - 1;
    localparam int unsigned REF_UV_MAX = 4000000;
    localparam int unsigned GAIN_MAX   = (1 << GAIN_W) - 1;

    // The settling wait after the last report is long enough for a sample set
    // still in flight to finish and for the block to be idle again.
    localparam int SETTLE_CYCLES = 80;
    // Cycles without any transaction before the run is declared hung.
    localparam int STALL_LIMIT = 3000;
    localparam int ITEMS_PER_SETTING = 150;
    localparam int NUM_SETTINGS = 9;

    // Setting kinds used by load_setting.
    localparam int CFG_ALL_MAX  = 0;
    localparam int CFG_REF_ZERO = 1;
    localparam int CFG_DEFAULT  = 2;
    localparam int CFG_GAIN_ZERO = 3;
    localparam int CFG_RANDOM   = 4;

    typedef struct packed {
        logic signed [AVG_W-1:0] min_avg;
        logic                    empty;
        logic [RPT_CNT_W-1:0]    reads;
    } cell_report_t;

    // Scoreboard: mirrors the registers and the period state of the block and
    // holds the reports that are still to come out.
    class cell_report_board;
        logic [REF_W-1:0]  ref_uv;
        logic [GAIN_W-1:0] tap_gain [3];
        longint            cell_sum [3];
        int unsigned       sets_counted;
        cell_report_t      due_reports [$];
        int unsigned       failures;

        function new();
            ref_uv       = RST_REF_UV;
            tap_gain[0]  = RST_GAIN_ONE;
            tap_gain[1]  = RST_GAIN_TWO;
            tap_gain[2]  = RST_GAIN_THREE;
            cell_sum     = '{0, 0, 0};
            sets_counted = 0;
            failures     = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_REF_UV:     ref_uv = value[REF_W-1:0];
                REG_GAIN_ONE:   tap_gain[0] = value[GAIN_W-1:0];
                REG_GAIN_TWO:   tap_gain[1] = value[GAIN_W-1:0];
                REG_GAIN_THREE: tap_gain[2] = value[GAIN_W-1:0];
                default:        ;
            endcase
        endfunction

        function int pending();
            return due_reports.size();
        endfunction

        // Tap voltage in microvolts: one exact product, one truncating division.
        function longint tap_volts(logic [ADC_W-1:0] code, logic [GAIN_W-1:0] gain,
                                   logic [ADC_W-1:0] ref_code);
            longint unsigned num;
            longint unsigned den;
            num = 64'(ref_uv) * 64'(code) * 64'(gain);
            den = 64'(ref_code) << FRAC_W;
            return longint'(num / den);
        endfunction

        function longint add_clamped(longint a, longint b);
            longint s;
            s = a + b;
            if (s > SUM_HI) s = SUM_HI;
            if (s < SUM_LO) s = SUM_LO;
            return s;
        endfunction

        function void note_item(logic act, logic [IN_TDATA_W-1:0] data);
            logic [ADC_W-1:0] ref_code;
            longint           tv [3];
            longint           avg [3];
            longint           low;
            cell_report_t     want;
            ref_code = data[ADC_W-1:0];
            if (act == ACT_SAMPLE) begin
                // A zero reference code or a full count leaves the period as it is.
                if (ref_code == 0 || sets_counted >= COUNT_FULL) return;
                for (int i = 0; i < 3; i++) begin
                    tv[i] = tap_volts(data[(i + 1) * ADC_W +: ADC_W], tap_gain[i], ref_code);
                end
                cell_sum[0] = add_clamped(cell_sum[0], tv[0]);
                cell_sum[1] = add_clamped(cell_sum[1], tv[1] - tv[0]);
                cell_sum[2] = add_clamped(cell_sum[2], tv[2] - tv[1]);
                sets_counted++;
                return;
            end
            if (sets_counted == 0) begin
                want.min_avg = '0;
                want.empty   = 1'b1;
                want.reads   = '0;
            end else begin
                for (int i = 0; i < 3; i++) begin
                    avg[i] = cell_sum[i] / longint'(sets_counted);
                end
                // Ties keep the later cell; the value is the same either way.
                if (avg[0] < avg[1]) low = (avg[0] < avg[2]) ? avg[0] : avg[2];
                else low = (avg[1] < avg[2]) ? avg[1] : avg[2];
                if (low > AVG_HI) low = AVG_HI;
                if (low < AVG_LO) low = AVG_LO;
                want.min_avg = low[AVG_W-1:0];
                want.empty   = 1'b0;
                want.reads   = RPT_CNT_W'((sets_counted > READS_FULL) ? READS_FULL
                                                                      : sets_counted);
            end
            due_reports.push_back(want);
            cell_sum     = '{0, 0, 0};
            sets_counted = 0;
        endfunction

        function void check_report(logic [OUT_TDATA_W-1:0] data, logic flag);
            cell_report_t got;
            cell_report_t want;
            got.min_avg = data[AVG_W-1:0];
            got.empty   = flag;
            got.reads   = data[AVG_W +: RPT_CNT_W];
            if (due_reports.size() == 0) begin
                $display("%0t: unexpected report, actual min %0d empty %0b reads %0d",
                         $time, got.min_avg, got.empty, got.reads);
                failures++;
                return;
            end
            want = due_reports.pop_front();
            if (got.min_avg !== want.min_avg) begin
                $display("%0t: min_cell_average expected %0d actual %0d",
                         $time, want.min_avg, got.min_avg);
                failures++;
            end
            if (got.empty !== want.empty) begin
                $display("%0t: period_empty expected %0b actual %0b",
                         $time, want.empty, got.empty);
                failures++;
            end
            if (got.reads !== want.reads) begin
                $display("%0t: reads_in_period expected %0d actual %0d",
                         $time, want.reads, got.reads);
                failures++;
            end
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [CFG_ADDR_W-1:0]   paddr;
    logic [CFG_DATA_W-1:0]   pwdata;
    logic [CFG_DATA_W-1:0]   prdata;
    logic                    pready;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    // reference_sample, tap_one_sample, tap_two_sample, tap_three_sample
    logic [IN_TDATA_W-1:0]   s_axis_tdata;
    // action
    logic                    s_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    // min_cell_average, reads_in_period
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    // period_empty
    logic                    m_axis_tuser;

    cell_report_board board = new();

    // Percentages of cycles in which the sender holds back or the receiver stalls.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int quiet_cycles  = 0;

    battery_cell_min_average_monitor u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // The receiver decides at each falling edge whether it takes a report in the
    // following cycle.
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Every report transaction is checked at the rising edge that completes it.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            board.check_report(m_axis_tdata, m_axis_tuser);
        end
    end

    // Watchdog: any transaction on either stream or the configuration port
    // restarts the count of quiet cycles.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("battery_cell_min_average_monitor_tb: FAIL");
            $finish;
        end
    end

    function automatic logic [IN_TDATA_W-1:0] pack_set(logic [ADC_W-1:0] ref_code,
                                                      logic [ADC_W-1:0] t1,
                                                      logic [ADC_W-1:0] t2,
                                                      logic [ADC_W-1:0] t3);
        return IN_TDATA_W'({t3, t2, t1, ref_code});
    endfunction

    // Tap codes lean toward the ends of the range.
    function automatic logic [ADC_W-1:0] pick_code();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return ADC_W'($urandom_range((1 << ADC_W) - 1));
        endcase
    endfunction

    // Reference codes: some zero (dropped sets), some tiny (huge tap voltages).
    function automatic logic [ADC_W-1:0] pick_ref_code();
        case ($urandom_range(15))
            0:       return '0;
            1:       return ADC_W'($urandom_range(3, 1));
            2:       return '1;
            default: return ADC_W'($urandom_range((1 << ADC_W) - 1, 1));
        endcase
    endfunction

    // One transaction on the sample stream. The scoreboard learns of it at the
    // rising edge where it is taken.
    task automatic send_item(input logic act, input logic [IN_TDATA_W-1:0] data);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= data;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        board.note_item(act, data);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the rising
    // edge where pready is seen high during the access.
    task automatic write_register(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        board.set_register(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Stop sending, wait for every outstanding report, then give the block time
    // to finish any sample set that produces no report.
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_setting(input int kind);
        logic [CFG_DATA_W-1:0] uv;
        logic [CFG_DATA_W-1:0] g [3];
        uv = CFG_DATA_W'($urandom_range(REF_UV_MAX));
        for (int i = 0; i < 3; i++) begin
            g[i] = CFG_DATA_W'($urandom_range(GAIN_MAX));
        end
        case (kind)
            CFG_ALL_MAX: begin
                uv = REF_UV_MAX;
                g  = '{GAIN_MAX, GAIN_MAX, GAIN_MAX};
            end
            CFG_REF_ZERO: uv = '0;
            CFG_DEFAULT: begin
                uv = CFG_DATA_W'(RST_REF_UV);
                g  = '{CFG_DATA_W'(RST_GAIN_ONE), CFG_DATA_W'(RST_GAIN_TWO),
                       CFG_DATA_W'(RST_GAIN_THREE)};
            end
            CFG_GAIN_ZERO: g = '{0, 0, 0};
            default: begin
                // Random setting, with a gain now and then pinned to an end.
                for (int i = 0; i < 3; i++) begin
                    case ($urandom_range(7))
                        0:       g[i] = '0;
                        1:       g[i] = GAIN_MAX;
                        default: ;
                    endcase
                end
            end
        endcase
        write_register(REG_REF_UV, uv);
        write_register(REG_GAIN_ONE, g[0]);
        write_register(REG_GAIN_TWO, g[1]);
        write_register(REG_GAIN_THREE, g[2]);
    endtask

    // Random periods: mostly short, sometimes long, each closed by an
    // end-of-period transaction whose sample fields hold random junk.
    task automatic run_periods(input int budget);
        int               counted;
        int               span;
        logic [ADC_W-1:0] ref_code;
        counted = 0;
        while (counted < budget) begin
            span = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(10);
            repeat (span) begin
                ref_code = pick_ref_code();
                send_item(ACT_SAMPLE, pack_set(ref_code, pick_code(), pick_code(), pick_code()));
                counted++;
            end
            send_item(ACT_REPORT, IN_TDATA_W'({$urandom, $urandom}));
            counted++;
        end
    endtask

    int setting_kind [NUM_SETTINGS] = '{CFG_RANDOM, CFG_ALL_MAX, CFG_GAIN_ZERO,
                                        CFG_RANDOM, CFG_REF_ZERO, CFG_RANDOM,
                                        CFG_DEFAULT, CFG_ALL_MAX, CFG_RANDOM};

    initial begin
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ACT_SAMPLE;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 24;
        recv_idle_pct = 52;

        // Directed part, run with the register values left by reset.
        // A report right after reset sees an empty period.
        send_item(ACT_REPORT, '0);
        // A zero reference code is dropped, so the period is still empty.
        send_item(ACT_SAMPLE, pack_set('0, '1, '1, '1));
        send_item(ACT_REPORT, '0);
        // All taps at zero give zero volts on every cell.
        send_item(ACT_SAMPLE, pack_set('1, '0, '0, '0));
        send_item(ACT_REPORT, '0);
        // Mixed set where a tiny reference drives the middle cell far negative,
        // so the minimum clamps at the bottom of the 32-bit range.
        send_item(ACT_SAMPLE, pack_set('1, '1, '1, '1));
        send_item(ACT_SAMPLE, pack_set(12'd2048, 12'd1000, 12'd2000, 12'd3000));
        send_item(ACT_SAMPLE, pack_set(12'd1, '1, '0, '1));
        send_item(ACT_REPORT, '0);
        // Evenly spread taps over a reference code of one push every cell above
        // the top of the 32-bit range.
        send_item(ACT_SAMPLE, pack_set(12'd1, 12'd1024, 12'd2048, 12'd3072));
        send_item(ACT_REPORT, '0);
        // The sample fields of an end-of-period transaction are ignored.
        send_item(ACT_REPORT, pack_set('1, '1, '1, '1));
        // Alternating bit patterns, with the third tap at all ones and then all zeros.
        send_item(ACT_SAMPLE, pack_set(12'hAAA, 12'h555, 12'hAAA, 12'hFFF));
        send_item(ACT_SAMPLE, pack_set(12'h555, 12'hAAA, 12'h555, 12'h000));
        send_item(ACT_REPORT, pack_set(12'h555, 12'hAAA, 12'h555, 12'hAAA));
        // A reference code of one with zero taps, then a descending staircase.
        send_item(ACT_SAMPLE, pack_set(12'd1, '0, '0, '0));
        send_item(ACT_SAMPLE, pack_set(12'd4000, 12'd3000, 12'd2000, 12'd1000));
        send_item(ACT_REPORT, '0);

        // Random part: three idling regimes, three register settings in each.
        for (int s = 0; s < NUM_SETTINGS; s++) begin
            if (s == 3) begin
                send_idle_pct = 52;
                recv_idle_pct = 24;
            end
            if (s == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            settle();
            load_setting(setting_kind[s]);
            run_periods(ITEMS_PER_SETTING);
        end

        settle();
        if (board.failures == 0) begin
            $display("battery_cell_min_average_monitor_tb: PASS");
        end else begin
            $display("battery_cell_min_average_monitor_tb: FAIL");
        end
        $finish;
    end

endmodule
